@@ hw/rtl/mpwd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwd_pkg: shared types and constants for the Manchester pulse-width decoder
// Register indexes, reset values, field widths and the structs that travel
// between the window unit, the decode unit and the top level.
// ----------------------------------------------------------------------------
package mpwd_pkg;

  localparam int TICK_W  = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_HALF_MIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_HALF_MAX = 2'd1;
  localparam logic [IDX_W-1:0] REG_FULL_MIN = 2'd2;
  localparam logic [IDX_W-1:0] REG_FULL_MAX = 2'd3;

  localparam logic [CFG_W-1:0] HALF_MIN_RST = 16'd1239;
  localparam logic [CFG_W-1:0] HALF_MAX_RST = 16'd1539;
  localparam logic [CFG_W-1:0] FULL_MIN_RST = 16'd2628;
  localparam logic [CFG_W-1:0] FULL_MAX_RST = 16'd2928;

  typedef struct packed {
    logic half;
    logic full;
  } match_t;

  typedef struct packed {
    logic               frame_valid;
    logic [DATA_W-1:0]  data_word;
    logic [COUNT_W-1:0] bit_count;
  } result_t;

endpackage

@@ hw/rtl/mpwd_window.sv @@
// ----------------------------------------------------------------------------
// mpwd_window: timing window registers and interval classifier
// Holds the four bound registers and flags an interval as half or full bit.
// ----------------------------------------------------------------------------
module mpwd_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mpwd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mpwd_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [mpwd_pkg::TICK_W-1:0]   ticks,
  output mpwd_pkg::match_t              match
);

  logic [mpwd_pkg::CFG_W-1:0] half_min_r;
  logic [mpwd_pkg::CFG_W-1:0] half_max_r;
  logic [mpwd_pkg::CFG_W-1:0] full_min_r;
  logic [mpwd_pkg::CFG_W-1:0] full_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_min_r <= mpwd_pkg::HALF_MIN_RST;
      half_max_r <= mpwd_pkg::HALF_MAX_RST;
      full_min_r <= mpwd_pkg::FULL_MIN_RST;
      full_max_r <= mpwd_pkg::FULL_MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mpwd_pkg::REG_HALF_MIN: half_min_r <= cfg_wdata;
        mpwd_pkg::REG_HALF_MAX: half_max_r <= cfg_wdata;
        mpwd_pkg::REG_FULL_MIN: full_min_r <= cfg_wdata;
        mpwd_pkg::REG_FULL_MAX: full_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // inclusive bounds; min above max simply never matches
  assign match.half = (ticks >= half_min_r) && (ticks <= half_max_r);
  assign match.full = (ticks >= full_min_r) && (ticks <= full_max_r);

endmodule

@@ hw/rtl/mpwd_decode.sv @@
// ----------------------------------------------------------------------------
// mpwd_decode: Manchester bit decoder state
// Phase tracking, bit value, shift word, bit and interval counters.
// ----------------------------------------------------------------------------
module mpwd_decode #(
  parameter int MAX_INTERVALS = 60,
  parameter int WORD_BITS     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              frame_end,
  input  mpwd_pkg::match_t  match,
  output mpwd_pkg::result_t result
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_INTERVALS);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_MID    = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_FAIL   = 2'd3;

  logic [1:0]                      phase_r, phase_nxt;
  logic                            bit_r, bit_nxt;
  logic [WORD_BITS-1:0]            shift_r, shift_nxt;
  logic [mpwd_pkg::COUNT_W-1:0]    bits_r, bits_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            push;
  logic                            push_val;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_val  = bit_r;
    if (step) begin
      if (frame_end) begin
        phase_nxt = PH_START;
        bit_nxt   = 1'b1;
        cnt_nxt   = '0;
      end else if (cnt_r < CNT_LIMIT) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        unique case (phase_r)
          PH_START: begin
            if (match.half) begin
              bit_nxt   = 1'b1;
              phase_nxt = PH_MID;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_MID: begin
            // full bit wins where the windows overlap
            priority if (match.full) begin
              bit_nxt  = ~bit_r;
              push     = 1'b1;
              push_val = ~bit_r;
            end else if (match.half) begin
              phase_nxt = PH_SECOND;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_SECOND: begin
            if (match.half) begin
              push      = 1'b1;
              phase_nxt = PH_MID;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    if (step && frame_end) begin
      shift_nxt = '0;
      bits_nxt  = '0;
    end else if (push) begin
      shift_nxt = {shift_r[WORD_BITS-2:0], push_val};
      if (bits_r != mpwd_pkg::COUNT_MAX) begin
        bits_nxt = bits_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      bit_r   <= 1'b1;
      shift_r <= '0;
      bits_r  <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  generate
    if (WORD_BITS >= mpwd_pkg::DATA_W) begin : g_word_wide
      assign result.data_word = shift_r[mpwd_pkg::DATA_W-1:0];
    end else begin : g_word_narrow
      assign result.data_word = {{(mpwd_pkg::DATA_W - WORD_BITS){1'b0}}, shift_r};
    end
  endgenerate

  assign result.frame_valid = (phase_r == PH_MID) && (bits_r[2:0] == 3'd0);
  assign result.bit_count   = bits_r;

endmodule

@@ hw/rtl/manchester_pulse_width_decoder.sv @@
// ----------------------------------------------------------------------------
// manchester_pulse_width_decoder: DALI-style Manchester frame decoder
// Classifies bus edge intervals as half or full bits and assembles frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one item per bus edge interval (in_interval_ticks), or an
//         end-of-frame mark from the idle timeout (in_frame_end = 1, ticks
//         ignored). Valid/ready handshake.
//   out_* channel: one item per end-of-frame mark carrying frame_valid, the
//         decoded word (newest bit in bit zero) and the bit count (sat. 63).
//   cfg_* port: write-only, indexes 0..3 = half min, half max, full min, full
//         max tick bounds. Users write only while the block is idle; unenforced.
// Timing:
//   Items are captured in an input register; the window compare and the
//   decode state update then run on it combinationally. An end mark goes
//   from the input register into the output register, which drives
//   out_valid. One item is taken every cycle; the input stage holds only
//   while an end mark waits for a full output register that the receiver
//   is not draining.
// Reset: synchronous, active low; bounds return to their defaults, decoder
//   waits for the start half bit, both pipeline registers are empty.
// ----------------------------------------------------------------------------
module manchester_pulse_width_decoder #(
  parameter int MAX_INTERVALS = 60,
  parameter int WORD_BITS     = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mpwd_pkg::TICK_W-1:0]      in_interval_ticks,
  input  logic                             in_frame_end,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_frame_valid,
  output logic [mpwd_pkg::DATA_W-1:0]      out_data_word,
  output logic [mpwd_pkg::COUNT_W-1:0]     out_bit_count,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [mpwd_pkg::IDX_W-1:0]       cfg_index,
  input  logic [mpwd_pkg::CFG_W-1:0]       cfg_wdata
);

  // input register stage
  logic                          s1_vld_r;
  logic [mpwd_pkg::TICK_W-1:0]   s1_ticks_r;
  logic                          s1_end_r;

  // output register stage
  logic                          out_vld_r;
  mpwd_pkg::result_t             out_res_r;

  mpwd_pkg::match_t              match;
  mpwd_pkg::result_t             dec_res;
  logic                          out_free;
  logic                          s1_step;
  logic                          load_out;

  // an interval never needs the output; an end mark needs a free slot
  assign out_free = !out_vld_r || out_ready;
  assign s1_step  = s1_vld_r && (!s1_end_r || out_free);
  assign load_out = s1_step && s1_end_r;
  assign in_ready = !s1_vld_r || s1_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ticks_r <= in_interval_ticks;
      s1_end_r   <= in_frame_end;
    end
  end

  mpwd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ticks     (s1_ticks_r),
    .match     (match)
  );

  mpwd_decode #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .WORD_BITS     (WORD_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_step),
    .frame_end (s1_end_r),
    .match     (match),
    .result    (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_frame_valid = out_res_r.frame_valid;
  assign out_data_word   = out_res_r.data_word;
  assign out_bit_count   = out_res_r.bit_count;

`ifndef NO_ASSERTIONS
  // a valid frame always carries whole bytes
  a_valid_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.frame_valid) |-> (out_res_r.bit_count[2:0] == 3'd0))
    else $error("valid frame with partial byte");

  // the input stage only stalls behind a blocked end mark
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && s1_end_r && out_vld_r && !out_ready))
    else $error("input stalled without a blocked frame end");

  // a new result only appears from an end mark leaving the input stage
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(load_out))
    else $error("result produced without a frame end");
`endif

endmodule

@@ tb/manchester_pulse_width_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// manchester_pulse_width_decoder_tb: self-checking bench for the frame decoder
// Feeds edge intervals and end-of-frame marks over valid/ready and predicts
// every frame report with a cycle-free decode model. Several window settings
// are used, including overlapping, empty and single-value windows. Both sides
// idle at random, and the result side holds off once to fill the pipeline.
// ----------------------------------------------------------------------------
module manchester_pulse_width_decoder_tb;

  localparam int TICK_W  = mpwd_pkg::TICK_W;
  localparam int CFG_W   = mpwd_pkg::CFG_W;
  localparam int IDX_W   = mpwd_pkg::IDX_W;
  localparam int DATA_W  = mpwd_pkg::DATA_W;
  localparam int COUNT_W = mpwd_pkg::COUNT_W;

  localparam int MAX_INTERVALS  = 60;
  localparam int WORD_BITS      = 32;
  localparam int DRAIN_CYCLES   = 6;       // idle time after the last owed report
  localparam int RX_HOLD_CYCLES = 300;     // long result-side stall
  localparam int TIMEOUT        = 4000000; // watchdog time limit

  // Tracks the decode state of the current frame and holds the frame reports
  // that the block still owes, oldest first.
  class frame_tracker #(int MAX_INTERVALS = 60, int WORD_BITS = 32);
    typedef enum logic [1:0] {
      AWAIT_START,
      AT_MID_BIT,
      AWAIT_SECOND_HALF,
      FRAME_FAILED
    } decode_phase_t;

    logic [mpwd_pkg::CFG_W-1:0]   half_lo, half_hi, full_lo, full_hi;
    decode_phase_t                phase;
    logic                         level;
    logic [WORD_BITS-1:0]         shift_reg;
    logic [mpwd_pkg::COUNT_W-1:0] nbits;
    int unsigned                  intervals;
    mpwd_pkg::result_t            owed_frames[$];
    int                           errors;

    function new();
      half_lo = mpwd_pkg::HALF_MIN_RST;
      half_hi = mpwd_pkg::HALF_MAX_RST;
      full_lo = mpwd_pkg::FULL_MIN_RST;
      full_hi = mpwd_pkg::FULL_MAX_RST;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase     = AWAIT_START;
      level     = 1'b1;
      shift_reg = '0;
      nbits     = '0;
      intervals = 0;
    endfunction

    function void set_reg(logic [mpwd_pkg::IDX_W-1:0] idx,
                          logic [mpwd_pkg::CFG_W-1:0] val);
      case (idx)
        mpwd_pkg::REG_HALF_MIN: half_lo = val;
        mpwd_pkg::REG_HALF_MAX: half_hi = val;
        mpwd_pkg::REG_FULL_MIN: full_lo = val;
        mpwd_pkg::REG_FULL_MAX: full_hi = val;
        default: ;
      endcase
    endfunction

    function void shift_in();
      shift_reg = {shift_reg[WORD_BITS-2:0], level};
      if (nbits != mpwd_pkg::COUNT_MAX) nbits++;
    endfunction

    // One accepted item: an interval advances the decode, an end mark owes a report.
    function void take_item(logic [mpwd_pkg::TICK_W-1:0] ticks, logic frame_end);
      mpwd_pkg::result_t rep;
      logic is_half, is_full;
      if (frame_end) begin
        rep.frame_valid = (phase == AT_MID_BIT) && (nbits[2:0] == 3'd0);
        rep.data_word   = shift_reg[mpwd_pkg::DATA_W-1:0];
        rep.bit_count   = nbits;
        owed_frames.push_back(rep);
        clear_frame();
        return;
      end
      if (intervals >= MAX_INTERVALS) return;
      intervals++;
      is_half = (ticks >= half_lo) && (ticks <= half_hi);
      is_full = (ticks >= full_lo) && (ticks <= full_hi);
      case (phase)
        AWAIT_START: begin
          level = 1'b1;
          phase = is_half ? AT_MID_BIT : FRAME_FAILED;
        end
        AT_MID_BIT: begin
          // full wins when the two windows overlap
          if (is_full) begin
            level = ~level;
            shift_in();
          end else if (is_half) begin
            phase = AWAIT_SECOND_HALF;
          end else begin
            phase = FRAME_FAILED;
          end
        end
        AWAIT_SECOND_HALF: begin
          if (is_half) begin
            shift_in();
            phase = AT_MID_BIT;
          end else begin
            phase = FRAME_FAILED;
          end
        end
        default: ;
      endcase
    endfunction

    function void match_frame(logic fv, logic [mpwd_pkg::DATA_W-1:0] word,
                              logic [mpwd_pkg::COUNT_W-1:0] cnt);
      mpwd_pkg::result_t want;
      if (owed_frames.size() == 0) begin
        $error("frame report with none owed: frame_valid %0d data_word %h bit_count %0d",
               fv, word, cnt);
        errors++;
        return;
      end
      want = owed_frames.pop_front();
      if (want.frame_valid !== fv) begin
        $error("frame_valid: expected %0d, got %0d", want.frame_valid, fv);
        errors++;
      end
      if (want.data_word !== word) begin
        $error("data_word: expected %h, got %h", want.data_word, word);
        errors++;
      end
      if (want.bit_count !== cnt) begin
        $error("bit_count: expected %0d, got %0d", want.bit_count, cnt);
        errors++;
      end
    endfunction
  endclass

  typedef frame_tracker #(MAX_INTERVALS, WORD_BITS) tracker_t;

  // how a generated frame is spoiled, if at all
  typedef enum {FLAW_NONE, FLAW_STRAY, FLAW_DANGLING} frame_flaw_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [TICK_W-1:0]  in_interval_ticks;
  logic               in_frame_end;
  logic               out_valid;
  logic               out_ready;
  logic               out_frame_valid;
  logic [DATA_W-1:0]  out_data_word;
  logic [COUNT_W-1:0] out_bit_count;
  logic               cfg_wr_en;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  tracker_t tracker = new();

  int sent_items = 0;
  int tx_quiet   = 0;     // items left that the sender offers back to back
  int rx_quiet   = 0;     // results left that the receiver takes back to back
  bit hold_rx    = 1'b0;  // asks the receiver for one long hold-off

  manchester_pulse_width_decoder #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .WORD_BITS    (WORD_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_interval_ticks(in_interval_ticks),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_valid  (out_frame_valid),
    .out_data_word    (out_data_word),
    .out_bit_count    (out_bit_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle cycles before the next item. Now and then a run of items goes with
  // no idling at all, so back-to-back traffic is covered too.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Tick count inside [lo, hi]; an empty window gets any value.
  function automatic logic [TICK_W-1:0] pick_window(input logic [CFG_W-1:0] lo, hi);
    if (lo <= hi) return TICK_W'($urandom_range(hi, lo));
    return TICK_W'($urandom_range(0, 65535));
  endfunction

  // Offer one item and hold it until taken. Entered at a rising edge;
  // valid stays high when the next item follows with no gap.
  task automatic send_item(input logic [TICK_W-1:0] ticks, input logic frame_end);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_interval_ticks <= ticks;
    in_frame_end      <= frame_end;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(ticks, frame_end);
    sent_items++;
  endtask

  // Manchester encode: start half bit, then a full interval where the bit
  // value changes and a pair of halves where it repeats, then the end mark.
  task automatic send_frame(input logic [63:0] bits, input int nbits,
                            input frame_flaw_t flaw);
    logic level;
    int   i;
    int   stray_at;
    level    = 1'b1;
    stray_at = (nbits > 0) ? $urandom_range(0, nbits - 1) : 0;
    send_item(pick_window(tracker.half_lo, tracker.half_hi), 1'b0);
    for (i = nbits - 1; i >= 0; i--) begin
      if (flaw == FLAW_STRAY && i == stray_at)
        send_item(TICK_W'($urandom), 1'b0);
      if (bits[i] != level) begin
        send_item(pick_window(tracker.full_lo, tracker.full_hi), 1'b0);
        level = bits[i];
      end else begin
        send_item(pick_window(tracker.half_lo, tracker.half_hi), 1'b0);
        send_item(pick_window(tracker.half_lo, tracker.half_hi), 1'b0);
      end
    end
    // a lone half bit leaves the decoder waiting for its partner
    if (flaw == FLAW_DANGLING)
      send_item(pick_window(tracker.half_lo, tracker.half_hi), 1'b0);
    send_item(TICK_W'($urandom), 1'b1);
  endtask

  // Mostly clean frames of whole bytes; some odd lengths, some long enough
  // to run past the interval capacity, some noise and some spoiled frames.
  task automatic random_frame();
    int          sel;
    int          r;
    int          nbits;
    logic [63:0] bits;
    sel = $urandom_range(0, 9);
    r   = $urandom_range(0, 9);
    if (r < 5) nbits = 8;
    else if (r < 7) nbits = 16;
    else if (r < 9) nbits = $urandom_range(0, 12);
    else nbits = $urandom_range(32, 48);
    // all ones decodes from half bits alone
    bits = ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom};
    case (sel)
      0: begin
        repeat ($urandom_range(0, 5)) send_item(TICK_W'($urandom), 1'b0);
        send_item(TICK_W'($urandom), 1'b1);
      end
      1: send_frame(bits, nbits, FLAW_STRAY);
      2: send_frame(bits, nbits, FLAW_DANGLING);
      default: send_frame(bits, nbits, FLAW_NONE);
    endcase
  endtask

  task automatic run_random(input int budget);
    int start;
    start = sent_items;
    while (sent_items - start < budget) random_frame();
  endtask

  // Stop offering, wait for every owed report, then let the pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.owed_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // New window bounds, written only once the block is idle.
  task automatic next_windows(input logic [CFG_W-1:0] h_lo, h_hi, f_lo, f_hi);
    settle();
    write_reg(mpwd_pkg::REG_HALF_MIN, h_lo);
    write_reg(mpwd_pkg::REG_HALF_MAX, h_hi);
    write_reg(mpwd_pkg::REG_FULL_MIN, f_lo);
    write_reg(mpwd_pkg::REG_FULL_MAX, f_hi);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      gap = draw_gap(rx_quiet);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.match_frame(out_frame_valid, out_data_word, out_bit_count);
    end
  end

  initial begin : stimulus
    int i;
    in_valid          <= 1'b0;
    in_interval_ticks <= '0;
    in_frame_end      <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= mpwd_pkg::REG_HALF_MIN;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the default windows.
    // empty frame; the ticks of an end mark are ignored
    send_item(16'hFFFF, 1'b1);
    // start half bit only: valid with no bits
    send_item(16'd1239, 1'b0);
    send_item(16'd0, 1'b1);
    // ends while the second half is still awaited
    send_item(16'd1539, 1'b0);
    send_item(16'd1400, 1'b0);
    send_item(16'd1300, 1'b1);
    // window edges: two full bits, one half pair, three bits in all
    send_item(16'd1400, 1'b0);
    send_item(16'd2628, 1'b0);
    send_item(16'd2928, 1'b0);
    send_item(16'd1239, 1'b0);
    send_item(16'd1539, 1'b0);
    send_item(16'd0, 1'b1);
    // failed frame keeps counting intervals but decodes nothing more
    send_item(16'd1400, 1'b0);
    send_item(16'd65535, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd2700, 1'b1);
    // one clean byte
    send_frame(64'h55, 8, FLAW_NONE);

    // Receiver stalls for a long stretch while short frames pour in back to
    // back, so the output register fills and the input side must stall.
    hold_rx  = 1'b1;
    tx_quiet = 30;
    for (i = 0; i < 15; i++) begin
      send_item(pick_window(tracker.half_lo, tracker.half_hi), 1'b0);
      send_item(TICK_W'($urandom), 1'b1);
    end

    run_random(60);
    // narrow windows
    next_windows(16'd10, 16'd20, 16'd30, 16'd40);
    run_random(60);
    // overlapping windows, bounds at both ends of the range
    next_windows(16'd0, 16'd40, 16'd30, 16'd65535);
    run_random(60);
    // full window empty: only repeated bits decode
    next_windows(16'd100, 16'd200, 16'd65535, 16'd0);
    run_random(60);
    // half window empty: every frame fails at its start
    next_windows(16'd65535, 16'd0, 16'd300, 16'd400);
    run_random(30);
    // single-value windows at the extremes
    next_windows(16'd0, 16'd0, 16'd65535, 16'd65535);
    run_random(60);
    // back to the reset bounds, written explicitly
    next_windows(mpwd_pkg::HALF_MIN_RST, mpwd_pkg::HALF_MAX_RST,
                 mpwd_pkg::FULL_MIN_RST, mpwd_pkg::FULL_MAX_RST);
    run_random(60);

    settle();
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
